// ===== hw/rtl/tsa_pkg.sv =====
package tsa_pkg;

  // field and register widths
  localparam int GRID_W    = 5;
  localparam int SPACING_W = 20;
  localparam int BASE_W    = 14;
  localparam int HIN_W     = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;
  localparam int SLOPE_W   = 14;
  localparam int ASPECT_W  = 15;
  localparam int ARROW_W   = 16;
  localparam int CELL_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_SPACING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ANGLE    = 2'd2;

  // 18-bit samples: a height difference never exceeds 2^18 in magnitude
  localparam int DIFF_W = 19;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int ROOT_W = 27;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int OPER_W = 28;
  localparam int CX_W   = 44;
  localparam int Z_W    = 24;
  localparam int STEPS  = 20;
  localparam int STEP_W = 5;

  localparam int RIGHT_ANGLE  = 9000;
  localparam int FLOOR_HEIGHT = -10000;
  localparam int ANGLE_FRAC_W = 8;
  localparam int Z_MAX        = RIGHT_ANGLE * (1 << ANGLE_FRAC_W);

  typedef struct packed {
    logic busy;
    logic done;
  } tsa_unit_stat_t;

  // arctangent of 2^-i, 1/256 hundredths of degree
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      5'd0:    v = 24'sd1152000;
      5'd1:    v = 24'sd680065;
      5'd2:    v = 24'sd359328;
      5'd3:    v = 24'sd182400;
      5'd4:    v = 24'sd91554;
      5'd5:    v = 24'sd45822;
      5'd6:    v = 24'sd22916;
      5'd7:    v = 24'sd11459;
      5'd8:    v = 24'sd5730;
      5'd9:    v = 24'sd2865;
      5'd10:   v = 24'sd1432;
      5'd11:   v = 24'sd716;
      5'd12:   v = 24'sd358;
      5'd13:   v = 24'sd179;
      5'd14:   v = 24'sd90;
      5'd15:   v = 24'sd45;
      5'd16:   v = 24'sd22;
      5'd17:   v = 24'sd11;
      5'd18:   v = 24'sd6;
      5'd19:   v = 24'sd3;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/tsa_ram.sv =====
module tsa_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tsa_isqrt.sv =====
module tsa_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tsa_pkg::RAD_W-1:0]     radicand_i,
  output tsa_pkg::tsa_unit_stat_t       stat_o,
  output logic [tsa_pkg::ROOT_W-1:0]    root_o
);
  import tsa_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  op_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;

  logic [REM_W-1:0] rem_sh, trial;

  // one root bit per cycle, restoring recurrence
  assign rem_sh = {rem_q[REM_W-3:0], op_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        op_q   <= radicand_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        op_q <= {op_q[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

// ===== hw/rtl/tsa_cordic.sv =====
module tsa_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tsa_pkg::OPER_W-1:0]    y_i,
  input  logic [tsa_pkg::OPER_W-1:0]    x_i,
  output tsa_pkg::tsa_unit_stat_t       stat_o,
  output logic [tsa_pkg::SLOPE_W-1:0]   angle_o
);
  import tsa_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_NORM,
    C_ITER,
    C_FIN
  } cord_state_e;

  cord_state_e              state_q;
  logic signed [CX_W-1:0]   cx_q, cy_q;
  logic signed [Z_W-1:0]    z_q;
  logic [STEP_W-1:0]        step_q;
  logic [SLOPE_W-1:0]       angle_q;
  logic                     done_q;

  logic                     below32, below40;
  logic signed [CX_W-1:0]   mag_y, sh_y, sh_x;
  logic signed [Z_W-1:0]    z_clamp;
  logic [Z_W-1:0]           z_round;

  assign below32 = (cx_q[CX_W-1:32] == '0) && (cy_q[CX_W-1:32] == '0);
  assign below40 = (cx_q[CX_W-1:40] == '0) && (cy_q[CX_W-1:40] == '0);

  // cx stays positive; cy shifts by magnitude (round toward zero)
  assign mag_y = cy_q[CX_W-1] ? -cy_q : cy_q;
  assign sh_y  = mag_y >>> step_q;
  assign sh_x  = cx_q >>> step_q;

  always_comb begin
    if (z_q < 0) begin
      z_clamp = '0;
    end else if (z_q > Z_W'(Z_MAX)) begin
      z_clamp = Z_W'(Z_MAX);
    end else begin
      z_clamp = z_q;
    end
    z_round = (Z_W'(z_clamp) + Z_W'(1 << (ANGLE_FRAC_W - 1))) >> ANGLE_FRAC_W;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            cx_q   <= CX_W'(x_i);
            cy_q   <= CX_W'(y_i);
            z_q    <= '0;
            step_q <= '0;
            if (x_i == '0 && y_i == '0) begin
              angle_q <= '0;
              done_q  <= 1'b1;
            end else begin
              state_q <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (below32) begin
            cx_q <= cx_q <<< 8;
            cy_q <= cy_q <<< 8;
          end else if (below40) begin
            cx_q <= cx_q <<< 1;
            cy_q <= cy_q <<< 1;
          end else begin
            state_q <= C_ITER;
          end
        end
        C_ITER: begin
          cx_q <= cx_q + sh_y;
          if (!cy_q[CX_W-1]) begin
            cy_q <= cy_q - sh_x;
            z_q  <= z_q + atan_entry(step_q);
          end else begin
            cy_q <= cy_q + sh_x;
            z_q  <= z_q - atan_entry(step_q);
          end
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(STEPS - 1)) begin
            state_q <= C_FIN;
          end
        end
        C_FIN: begin
          angle_q <= z_round[SLOPE_W-1:0];
          done_q  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign stat_o.busy = (state_q != C_IDLE);
  assign stat_o.done = done_q;
  assign angle_o     = angle_q;

endmodule

// ===== hw/rtl/terrain_slope_aspect_stencil_core.sv =====
// Terrain slope / aspect / arrow stencil. Heights stream in raster order over a
// square grid (grid_side samples a side, saturated to 3..MAX_SIDE); tuser bit 0
// marks the first sample of a new grid. Each sample at row r >= 2, col c >= 2
// yields one result for interior cell (r-1, c-1): slope = atan(|grad|/spacing),
// aspect = atan(dv/dh) + 90 deg, and the arrow angle toward the highest of the
// nine window cells, all in hundredths of degree; tlast flags the final cell.
// A border sample passes only the accept and window-update steps. An interior
// sample adds differences and squaring (one shared 19x19 multiplier), the
// bit-serial square root, one or two passes of the shared CORDIC unit
// (normalizing shifts, 20 iterations, a round step and a handoff each; the
// slope pass ends without iterating when spacing and gradient are both zero,
// and the aspect pass is skipped when dh or dv is zero), and a load of the
// output register. s_axis_tready is low while a sample is in work. A finished
// result sits in the output register, so the next sample is taken while it
// waits to be transferred.
// The two line stores share one RAM; their contents are undefined until a
// grid has written them.
module terrain_slope_aspect_stencil_core #(
  parameter int MAX_SIDE    = 16,
  parameter int HEIGHT_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic                               cfg_we_i,
  input  logic [tsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tsa_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [17:0] height_sample
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [13:0] slope_deg, [28:14] aspect_deg,
                                      // [44:29] arrow_deg, [48:45] cell_row,
                                      // [52:49] cell_col
  output logic        m_axis_tlast    // last_cell
);
  import tsa_pkg::*;

  localparam int HB = HEIGHT_BITS;
  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = CW + 1;
  localparam int BW = (HB > 15) ? HB : 15;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DIFF,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_ROOT,
    S_SLOPE,
    S_ASPECT,
    S_DONE
  } core_state_e;

  // ---------------- configuration ----------------
  logic [GRID_W-1:0]    grid_side_q;
  logic [SPACING_W-1:0] spacing_q;
  logic [BASE_W-1:0]    base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= GRID_W'(11);
      spacing_q   <= SPACING_W'(100);
      base_q      <= BASE_W'(4500);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_SIDE:     grid_side_q <= cfg_data_i[GRID_W-1:0];
        CFG_SLOPE_SPACING: spacing_q   <= cfg_data_i[SPACING_W-1:0];
        CFG_BASE_ANGLE:    base_q      <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] side;
  always_comb begin
    if (grid_side_q < GRID_W'(3)) begin
      side = SW'(3);
    end else if (32'(grid_side_q) > MAX_SIDE) begin
      side = SW'(MAX_SIDE);
    end else begin
      side = SW'(grid_side_q);
    end
  end

  // ---------------- state ----------------
  core_state_e            state_q;
  logic [CW-1:0]          row_q, col_q;     // position of next sample
  logic [CW-1:0]          r_q, c_q;         // position of sample in work
  logic signed [HB-1:0]   h_q;
  logic signed [HB-1:0]   w_q [9];          // 3x3 window, scan order
  logic [DIFF_W-1:0]      mag_h_q, mag_v_q;
  logic                   dh_neg_q, dv_neg_q, dh_zero_q, dv_zero_q;
  logic [SQ_W-1:0]        prod_q, acc_q;
  logic [SLOPE_W-1:0]     slope_q;
  logic [ASPECT_W-1:0]    aspect_q;

  logic                   scan_act_q;
  logic [3:0]             scan_idx_q, best_idx_q;
  logic signed [BW-1:0]   best_q;

  logic                   out_valid_q;
  logic [55:0]            out_data_q;
  logic                   out_last_q;

  // ---------------- accept and position ----------------
  logic          accept;
  logic [CW-1:0] r_cur, c_cur;
  logic [SW-1:0] c_inc, r_inc;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    r_cur = s_axis_tuser[0] ? '0 : row_q;
    c_cur = s_axis_tuser[0] ? '0 : col_q;
    if (SW'(r_cur) >= side) begin
      r_cur = '0;
    end
    c_inc = SW'(c_cur) + 1'b1;
    r_inc = SW'(r_cur) + 1'b1;
  end

  // fold the 18-bit sample into HEIGHT_BITS
  logic signed [31:0]   h_ext;
  logic signed [HB-1:0] h_fold;
  assign h_ext  = 32'(signed'(s_axis_tdata[HIN_W-1:0]));
  assign h_fold = h_ext[HB-1:0];

  // ---------------- line stores: {upper, middle} ----------------
  logic [2*HB-1:0]      ram_rdata;
  logic signed [HB-1:0] up_rd, mid_rd;
  logic                 ram_we;

  assign ram_we = (state_q == S_READ);
  assign up_rd  = ram_rdata[2*HB-1:HB];
  assign mid_rd = ram_rdata[HB-1:0];

  tsa_ram #(
    .WIDTH (2 * HB),
    .DEPTH (MAX_SIDE)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_q),
    .wdata_i ({mid_rd, h_q}),
    .re_i    (accept),
    .raddr_i (c_cur),
    .rdata_o (ram_rdata)
  );

  // ---------------- differences ----------------
  logic signed [32:0] dh, dv;
  logic [32:0]        dh_mag, dv_mag;
  assign dh     = 33'(w_q[3]) - 33'(w_q[5]);
  assign dv     = 33'(w_q[1]) - 33'(w_q[7]);
  assign dh_mag = dh[32] ? 33'(-dh) : 33'(dh);
  assign dv_mag = dv[32] ? 33'(-dv) : 33'(dv);

  // shared squaring multiplier
  logic [DIFF_W-1:0] mul_a;
  assign mul_a = (state_q == S_MUL1) ? mag_h_q : mag_v_q;

  // ---------------- shared units ----------------
  tsa_unit_stat_t    sq_stat, cd_stat;
  logic              sq_start, cd_start;
  logic [ROOT_W-1:0] root;
  logic [OPER_W-1:0] cd_y, cd_x;
  logic [SLOPE_W-1:0] cd_angle;
  logic [SQ_W-1:0]   sum_sq;

  assign sum_sq   = acc_q + prod_q;
  assign sq_start = (state_q == S_SUM);

  tsa_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i ({sum_sq, 16'b0}),
    .stat_o     (sq_stat),
    .root_o     (root)
  );

  logic aspect_special;
  assign aspect_special = dh_zero_q || dv_zero_q;

  always_comb begin
    cd_start = 1'b0;
    cd_y     = OPER_W'(mag_v_q);
    cd_x     = OPER_W'(mag_h_q);
    if (state_q == S_ROOT && sq_stat.done) begin
      cd_start = 1'b1;
      cd_y     = OPER_W'(root);
      cd_x     = {spacing_q, 8'b0};
    end else if (state_q == S_SLOPE && cd_stat.done && !aspect_special) begin
      cd_start = 1'b1;
    end
  end

  tsa_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cd_start),
    .y_i     (cd_y),
    .x_i     (cd_x),
    .stat_o  (cd_stat),
    .angle_o (cd_angle)
  );

  // ---------------- arrow ----------------
  logic [BASE_W-1:0]         beta;
  logic signed [ARROW_W-1:0] beta_s, arrow;
  assign beta   = (base_q > BASE_W'(RIGHT_ANGLE)) ? BASE_W'(RIGHT_ANGLE) : base_q;
  assign beta_s = ARROW_W'(beta);

  // scan index = (row offset + 1) * 3 + (col offset + 1)
  always_comb begin
    unique case (best_idx_q)
      4'd8:    arrow = beta_s;
      4'd7:    arrow = ARROW_W'(RIGHT_ANGLE);
      4'd6:    arrow = ARROW_W'(2 * RIGHT_ANGLE) - beta_s;
      4'd3:    arrow = ARROW_W'(2 * RIGHT_ANGLE);
      4'd0:    arrow = ARROW_W'(2 * RIGHT_ANGLE) + beta_s;
      4'd1:    arrow = -ARROW_W'(RIGHT_ANGLE);
      4'd2:    arrow = -beta_s;
      default: arrow = '0;
    endcase
  end

  logic signed [BW-1:0] scan_val;
  assign scan_val = BW'(w_q[scan_idx_q]);

  logic [ASPECT_W-1:0] asp_calc;
  assign asp_calc = (dh_neg_q == dv_neg_q) ? ASPECT_W'(RIGHT_ANGLE) + ASPECT_W'(cd_angle)
                                           : ASPECT_W'(RIGHT_ANGLE) - ASPECT_W'(cd_angle);

  logic out_free, out_load;
  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (state_q == S_DONE) && out_free && !scan_act_q;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      scan_act_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces one leaving in the same cycle
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      // arrow scan runs alongside the difference, squaring and root steps
      if (scan_act_q) begin
        if (scan_val > best_q) begin
          best_q     <= scan_val;
          best_idx_q <= scan_idx_q;
        end
        scan_idx_q <= scan_idx_q + 1'b1;
        if (scan_idx_q == 4'd8) begin
          scan_act_q <= 1'b0;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            r_q <= r_cur;
            c_q <= c_cur;
            h_q <= h_fold;
            if (c_inc >= side) begin
              col_q <= '0;
              row_q <= (r_inc >= side) ? '0 : CW'(r_inc);
            end else begin
              col_q <= CW'(c_inc);
              row_q <= r_cur;
            end
            state_q <= S_READ;
          end
        end
        S_READ: begin
          w_q[0] <= w_q[1];
          w_q[1] <= w_q[2];
          w_q[2] <= up_rd;
          w_q[3] <= w_q[4];
          w_q[4] <= w_q[5];
          w_q[5] <= mid_rd;
          w_q[6] <= w_q[7];
          w_q[7] <= w_q[8];
          w_q[8] <= h_q;
          if (r_q >= CW'(2) && c_q >= CW'(2)) begin
            scan_act_q <= 1'b1;
            scan_idx_q <= '0;
            best_idx_q <= 4'd4;
            best_q     <= BW'(FLOOR_HEIGHT);
            state_q    <= S_DIFF;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DIFF: begin
          mag_h_q   <= dh_mag[DIFF_W-1:0];
          mag_v_q   <= dv_mag[DIFF_W-1:0];
          dh_neg_q  <= dh[32];
          dv_neg_q  <= dv[32];
          dh_zero_q <= (dh == '0);
          dv_zero_q <= (dv == '0);
          state_q   <= S_MUL1;
        end
        S_MUL1: begin
          prod_q  <= mul_a * mul_a;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          acc_q   <= prod_q;
          prod_q  <= mul_a * mul_a;
          state_q <= S_SUM;
        end
        S_SUM: begin
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_stat.done) begin
            state_q <= S_SLOPE;
          end
        end
        S_SLOPE: begin
          if (cd_stat.done) begin
            slope_q <= cd_angle;
            if (dh_zero_q) begin
              // vertical-only or flat cell
              if (dv_zero_q) begin
                aspect_q <= ASPECT_W'(RIGHT_ANGLE);
              end else if (dv_neg_q) begin
                aspect_q <= '0;
              end else begin
                aspect_q <= ASPECT_W'(2 * RIGHT_ANGLE);
              end
              state_q <= S_DONE;
            end else if (dv_zero_q) begin
              aspect_q <= ASPECT_W'(RIGHT_ANGLE);
              state_q  <= S_DONE;
            end else begin
              state_q <= S_ASPECT;
            end
          end
        end
        S_ASPECT: begin
          if (cd_stat.done) begin
            aspect_q <= asp_calc;
            state_q  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_data_q  <= {3'b0,
                            CELL_W'(32'(c_q) - 32'd1),
                            CELL_W'(32'(r_q) - 32'd1),
                            arrow, aspect_q, slope_q};
            out_last_q  <= (SW'(r_q) + 1'b1 == side) && (SW'(c_q) + 1'b1 == side);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------- assertions ----------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a sample is in work");

  a_last_on_diagonal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[48:45] == m_axis_tdata[52:49]))
    else $error("last cell off the diagonal");

  a_cordic_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cd_start |-> !cd_stat.busy)
    else $error("CORDIC started while busy");

  a_root_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> (!sq_stat.busy && !cd_stat.busy))
    else $error("square root started while a unit is busy");

endmodule
